/* src/assert_macros.svh */
// Assertion macros shared by the frustum culling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequent in the same cycle.
`define FCBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum cull assertion failed");

// Check that a condition implies a consequent in the next cycle.
`define FCBS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum cull assertion failed");

`endif

/* src/fcbs_pkg.sv */
// Shared constants and types for the frustum culling block.
package fcbs_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
   localparam int PLANE_COUNT          = 6;
   localparam int PLANE_FIELD_BITS     = 16;
   localparam int CSR_DATA_BITS        = 64;
   localparam int CSR_ADDR_BITS        = 6;
   localparam int CSR_INDEX_BITS       = 3;

   // Operation codes of an input item
   localparam logic OP_BOX    = 1'b0;
   localparam logic OP_SPHERE = 1'b1;

   // Visibility codes of a result
   localparam logic [1:0] VIS_OUTSIDE = 2'd0;
   localparam logic [1:0] VIS_PARTIAL = 2'd1;
   localparam logic [1:0] VIS_INSIDE  = 2'd2;

   typedef logic [CSR_DATA_BITS-1:0] plane_reg_type;

   // Per-plane test outcome handed to the final reduction
   typedef struct packed {
      logic box_hit;   // farthest box corner strictly in front
      logic sph_out;   // center distance at or below minus radius
      logic sph_in;    // center distance above radius
   } plane_flags_type;

endpackage

/* src/fcbs_csr.sv */
// APB-style register file holding the six frustum planes.
module fcbs_csr (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [fcbs_pkg::CSR_ADDR_BITS-1:0]       paddr,
   input  logic [fcbs_pkg::CSR_DATA_BITS-1:0]       pwdata,
   output logic [fcbs_pkg::CSR_DATA_BITS-1:0]       prdata,
   output logic                                     pready,
   output fcbs_pkg::plane_reg_type                  planes [fcbs_pkg::PLANE_COUNT]
);

   fcbs_pkg::plane_reg_type                 plane_ff [fcbs_pkg::PLANE_COUNT];
   logic [fcbs_pkg::CSR_INDEX_BITS-1:0]     index;
   logic                                    index_ok;
   logic                                    wr_en;

   // Decode the register index from the 8-byte slot
   assign index    = paddr[fcbs_pkg::CSR_ADDR_BITS-1:3];
   assign index_ok = 32'(index) < fcbs_pkg::PLANE_COUNT;
   assign wr_en    = psel && penable && pwrite && index_ok;
   assign pready   = 1'b1;

   // Write the addressed plane at the end of the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fcbs_pkg::PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (wr_en) begin
         plane_ff[index] <= pwdata;
      end
   end

   // Return the addressed plane, zero beyond the list
   always_comb begin
      prdata = '0;
      if (index_ok) begin
         prdata = plane_ff[index];
      end
   end

   assign planes = plane_ff;

endmodule

/* src/fcbs_plane_dist.sv */
// Three-stage plane distance pipeline for one frustum plane.
module fcbs_plane_dist #(
   parameter int COORD_BITS       = fcbs_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = fcbs_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic signed [COORD_BITS-1:0]  center_x,
   input  logic signed [COORD_BITS-1:0]  center_y,
   input  logic signed [COORD_BITS-1:0]  center_z,
   input  logic        [COORD_BITS-2:0]  extent_x,
   input  logic        [COORD_BITS-2:0]  extent_y,
   input  logic        [COORD_BITS-2:0]  extent_z,
   input  logic        [COORD_BITS-2:0]  radius,
   input  fcbs_pkg::plane_reg_type       plane,
   output fcbs_pkg::plane_flags_type     flags
);

   localparam int FB  = fcbs_pkg::PLANE_FIELD_BITS;
   localparam int PB  = FB + COORD_BITS;                   // signed product
   localparam int AB  = FB + COORD_BITS - 1;               // unsigned abs product
   localparam int WB  = FB + NORMAL_FRAC_BITS;             // scaled offset
   localparam int RB  = COORD_BITS - 1 + NORMAL_FRAC_BITS; // scaled radius
   localparam int DW  = ((PB > WB) ? PB : WB) + 4;         // distance sum

   logic signed [FB-1:0] nx, ny, nz, w;
   logic        [FB-1:0] anx, any, anz;

   logic signed [PB-1:0] px_in, py_in, pz_in, px_ff, py_ff, pz_ff;
   logic        [AB-1:0] ax_in, ay_in, az_in, ax_ff, ay_ff, az_ff;
   logic signed [WB-1:0] ws_in, ws_ff;
   logic        [RB-1:0] rs_in, rs1_ff, rs2_ff;

   logic signed [DW-1:0] dc_in, dc_ff;
   logic        [DW-1:0] as_in, as_ff;
   logic signed [DW-1:0] db;
   logic signed [DW-1:0] rs_ext;
   fcbs_pkg::plane_flags_type flags_in, flags_ff;

   // Unpack the plane fields
   assign nx  = plane[FB-1:0];
   assign ny  = plane[2*FB-1:FB];
   assign nz  = plane[3*FB-1:2*FB];
   assign w   = plane[4*FB-1:3*FB];
   assign anx = nx[FB-1] ? FB'(-nx) : FB'(nx);
   assign any = ny[FB-1] ? FB'(-ny) : FB'(ny);
   assign anz = nz[FB-1] ? FB'(-nz) : FB'(nz);

   // Stage one: products of normal and center, magnitudes and extents
   always_comb begin
      px_in = PB'(nx) * PB'(center_x);
      py_in = PB'(ny) * PB'(center_y);
      pz_in = PB'(nz) * PB'(center_z);
      ax_in = AB'(anx) * AB'(extent_x);
      ay_in = AB'(any) * AB'(extent_y);
      az_in = AB'(anz) * AB'(extent_z);
      ws_in = {w, {NORMAL_FRAC_BITS{1'b0}}};
      rs_in = {radius, {NORMAL_FRAC_BITS{1'b0}}};
   end

   // Stage two: center distance and box reach
   always_comb begin
      dc_in = DW'(px_ff) + DW'(py_ff) + DW'(pz_ff) + DW'(ws_ff);
      as_in = DW'(ax_ff) + DW'(ay_ff) + DW'(az_ff);
   end

   // Stage three: farthest corner distance and sphere bounds
   always_comb begin
      rs_ext           = $signed(DW'(rs2_ff));
      db               = dc_ff + $signed(as_ff);
      flags_in.box_hit = db > 0;
      flags_in.sph_out = dc_ff <= -rs_ext;
      flags_in.sph_in  = dc_ff > rs_ext;
   end

   // Advance the pipeline every cycle
   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      ws_ff    <= ws_in;
      rs1_ff   <= rs_in;
      dc_ff    <= dc_in;
      as_ff    <= as_in;
      rs2_ff   <= rs1_ff;
      flags_ff <= flags_in;
   end

   assign flags = flags_ff;

endmodule

/* src/frustum_cull_box_sphere.sv */
// Top level of the pipelined box and sphere frustum culling block.
//
// Tests one box or sphere per clock against the six planes in the register
// file; start is taken whenever busy is low, and busy never rises. Each
// test's result strobes on rsp_valid for one cycle, five cycles after the
// cycle in which start was taken, and must be taken then: the receiver cannot
// stall. The latency is set by the input register, the three-stage plane
// distance pipeline (multiply, sum, compare) and the output register that
// merges the six planes. Write planes only while no test is in flight.
`include "assert_macros.svh"

module frustum_cull_box_sphere #(
   parameter int COORD_BITS       = fcbs_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = fcbs_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic signed [COORD_BITS-1:0]         req_center_x,
   input  logic signed [COORD_BITS-1:0]         req_center_y,
   input  logic signed [COORD_BITS-1:0]         req_center_z,
   input  logic        [COORD_BITS-2:0]         req_extent_x,
   input  logic        [COORD_BITS-2:0]         req_extent_y,
   input  logic        [COORD_BITS-2:0]         req_extent_z,
   input  logic        [COORD_BITS-2:0]         req_radius,
   // result channel
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_visibility,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fcbs_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [fcbs_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [fcbs_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   localparam int NP = fcbs_pkg::PLANE_COUNT;

   fcbs_pkg::plane_reg_type   planes [NP];
   fcbs_pkg::plane_flags_type flags  [NP];

   logic                          accept;
   logic                          v0_ff, v1_ff, v2_ff, v3_ff;
   logic                          op0_ff, op1_ff, op2_ff, op3_ff;
   logic signed [COORD_BITS-1:0]  cx_ff, cy_ff, cz_ff;
   logic        [COORD_BITS-2:0]  ex_ff, ey_ff, ez_ff, r_ff;
   logic [NP-1:0]                 box_hit, sph_out, sph_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_visibility_ff, rsp_visibility_in;

   // The pipeline never stalls, so a transfer is taken in every cycle that start is high
   assign busy   = 1'b0;
   assign accept = start && !busy;

   fcbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .planes  (planes)
   );

   // Capture the command payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op0_ff <= req_operation;
         cx_ff  <= req_center_x;
         cy_ff  <= req_center_y;
         cz_ff  <= req_center_z;
         ex_ff  <= req_extent_x;
         ey_ff  <= req_extent_y;
         ez_ff  <= req_extent_z;
         r_ff   <= req_radius;
      end
      op1_ff <= op0_ff;
      op2_ff <= op1_ff;
      op3_ff <= op2_ff;
   end

   // Advance valid bits alongside the plane pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // One distance pipeline per plane
   for (genvar p = 0; p < NP; p++) begin : g_plane
      fcbs_plane_dist #(
         .COORD_BITS       (COORD_BITS),
         .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
      ) u_dist (
         .clock    (clock),
         .center_x (cx_ff),
         .center_y (cy_ff),
         .center_z (cz_ff),
         .extent_x (ex_ff),
         .extent_y (ey_ff),
         .extent_z (ez_ff),
         .radius   (r_ff),
         .plane    (planes[p]),
         .flags    (flags[p])
      );
      assign box_hit[p] = flags[p].box_hit;
      assign sph_out[p] = flags[p].sph_out;
      assign sph_in[p]  = flags[p].sph_in;
   end

   // Merge the six plane outcomes into one visibility code
   always_comb begin
      rsp_valid_in = v3_ff;
      if (op3_ff == fcbs_pkg::OP_BOX) begin
         rsp_visibility_in = (&box_hit) ? fcbs_pkg::VIS_PARTIAL : fcbs_pkg::VIS_OUTSIDE;
      end else if (|sph_out) begin
         rsp_visibility_in = fcbs_pkg::VIS_OUTSIDE;
      end else if (&sph_in) begin
         rsp_visibility_in = fcbs_pkg::VIS_INSIDE;
      end else begin
         rsp_visibility_in = fcbs_pkg::VIS_PARTIAL;
      end
   end

   // Hold the result for its single strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_visibility_ff <= rsp_visibility_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_visibility = rsp_visibility_ff;

   // Every accepted transfer yields a result
   `FCBS_ASSERT_IMP(a_latency, clock, reset, accept, ##5 rsp_valid)
   // No result appears without an earlier accepted transfer
   `FCBS_ASSERT_IMP(a_no_orphan, clock, reset, rsp_valid, $past(accept, 5))
   // A box test never reports fully inside
   `FCBS_ASSERT_IMP(a_box_code, clock, reset, rsp_valid && $past(req_operation == fcbs_pkg::OP_BOX, 5), rsp_visibility != fcbs_pkg::VIS_INSIDE)
   // The merge stage output follows the last pipeline valid bit
   `FCBS_ASSERT_NXT(a_merge_valid, clock, reset, v3_ff, rsp_valid)

endmodule

/* tb/frustum_cull_box_sphere_tb.sv */
// Self-checking testbench for the box and sphere frustum culling block.
module frustum_cull_box_sphere_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CBITS        = fcbs_pkg::COORD_BITS_DEF;
   localparam int FRAC         = fcbs_pkg::NORMAL_FRAC_BITS_DEF;
   localparam int NPL          = fcbs_pkg::PLANE_COUNT;
   localparam int DBITS        = fcbs_pkg::CSR_DATA_BITS;
   localparam int ABITS        = fcbs_pkg::CSR_ADDR_BITS;
   localparam int PHASE_ITEMS  = 193;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {
      STYLE_CUBE, STYLE_TILTED, STYLE_RAW, STYLE_CORNER, STYLE_ZERO
   } plane_style_type;

   typedef struct {
      logic                    op;
      logic signed [CBITS-1:0] cx, cy, cz;
      logic [CBITS-2:0]        ex, ey, ez, rad;
   } cull_req_type;

   // Tracks plane registers, predicts visibility and checks each result
   class cull_tracker;
      logic [DBITS-1:0] planes [NPL];
      logic [1:0]       pending_vis [$];
      int               mismatches;
      int               box_tests;
      int               sphere_tests;
      int               vis_seen [3];

      function new();
         foreach (planes[i]) planes[i] = '0;
         mismatches   = 0;
         box_tests    = 0;
         sphere_tests = 0;
         foreach (vis_seen[i]) vis_seen[i] = 0;
      endfunction

      function void set_plane(int idx, logic [DBITS-1:0] value);
         // indexes past the last plane are dropped by the block
         if (idx < NPL) planes[idx] = value;
      endfunction

      function logic [1:0] cull_verdict(cull_req_type r);
         longint     nx, ny, nz, w, plane_d, reach;
         int         n_in;
         logic [1:0] vis;
         reach = longint'(r.rad) <<< FRAC;
         vis   = fcbs_pkg::VIS_PARTIAL;
         n_in  = 0;
         for (int p = 0; p < NPL; p++) begin
            nx = longint'($signed(planes[p][15:0]));
            ny = longint'($signed(planes[p][31:16]));
            nz = longint'($signed(planes[p][47:32]));
            w  = longint'($signed(planes[p][63:48]));
            plane_d = nx * longint'(r.cx) + ny * longint'(r.cy) + nz * longint'(r.cz)
                      + (w <<< FRAC);
            if (r.op == fcbs_pkg::OP_BOX) begin
               // farthest corner along the normal
               plane_d += (nx < 0 ? -nx : nx) * longint'(r.ex)
                          + (ny < 0 ? -ny : ny) * longint'(r.ey)
                          + (nz < 0 ? -nz : nz) * longint'(r.ez);
               if (plane_d <= 0) vis = fcbs_pkg::VIS_OUTSIDE;
            end else begin
               if (plane_d <= -reach) vis = fcbs_pkg::VIS_OUTSIDE;
               if (plane_d > reach) n_in++;
            end
         end
         if (r.op == fcbs_pkg::OP_SPHERE && vis != fcbs_pkg::VIS_OUTSIDE && n_in == NPL)
            vis = fcbs_pkg::VIS_INSIDE;
         return vis;
      endfunction

      function void note_request(cull_req_type r);
         if (r.op == fcbs_pkg::OP_BOX) box_tests++;
         else sphere_tests++;
         pending_vis.push_back(cull_verdict(r));
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
      endfunction

      function void check_result(logic [1:0] got);
         logic [1:0] want;
         if (pending_vis.size() == 0) begin
            flag("result with nothing outstanding", 64'hx, {62'd0, got});
            return;
         end
         want = pending_vis.pop_front();
         if (got !== want) flag("visibility", {62'd0, want}, {62'd0, got});
         if (got <= fcbs_pkg::VIS_INSIDE) vis_seen[got]++;
      endfunction

      function int pending_count();
         return pending_vis.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_operation;
   logic signed [CBITS-1:0] req_center_x, req_center_y, req_center_z;
   logic [CBITS-2:0] req_extent_x, req_extent_y, req_extent_z, req_radius;
   logic rsp_valid;
   logic [1:0] rsp_visibility;
   logic psel, penable, pwrite;
   logic [ABITS-1:0] paddr;
   logic [DBITS-1:0] pwdata, prdata;
   logic pready;

   cull_tracker sb;
   int          cycle_count = 0;
   int          settings_run = 0;
   int          csr_accesses = 0;

   frustum_cull_box_sphere DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_extent_x   (req_extent_x),
      .req_extent_y   (req_extent_y),
      .req_extent_z   (req_extent_z),
      .req_radius     (req_radius),
      .rsp_valid      (rsp_valid),
      .rsp_visibility (rsp_visibility),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  sb.pending_count());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Note each accepted test and check each result transfer
   always @(posedge clock) begin
      cull_req_type seen;
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0) begin
            seen.op  = req_operation;
            seen.cx  = req_center_x;
            seen.cy  = req_center_y;
            seen.cz  = req_center_z;
            seen.ex  = req_extent_x;
            seen.ey  = req_extent_y;
            seen.ez  = req_extent_z;
            seen.rad = req_radius;
            sb.note_request(seen);
         end
         if (rsp_valid === 1'b1) sb.check_result(rsp_visibility);
      end
   end

   function automatic cull_req_type mk(logic op, int cx, int cy, int cz, int ex, int ey,
                                       int ez, int rad);
      cull_req_type r;
      r.op  = op;
      r.cx  = CBITS'(cx);
      r.cy  = CBITS'(cy);
      r.cz  = CBITS'(cz);
      r.ex  = (CBITS-1)'(ex);
      r.ey  = (CBITS-1)'(ey);
      r.ez  = (CBITS-1)'(ez);
      r.rad = (CBITS-1)'(rad);
      return r;
   endfunction

   // Axis-aligned plane: even index faces +axis, odd faces -axis
   function automatic logic [63:0] cube_plane(int idx, int offset);
      logic [15:0] n [3];
      foreach (n[k]) n[k] = '0;
      n[idx / 2] = (idx % 2) ? 16'hC000 : 16'h4000;
      return {16'(offset), n[2], n[1], n[0]};
   endfunction

   function automatic logic [15:0] corner_field();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [63:0] make_plane(plane_style_type style, int idx);
      case (style)
         STYLE_CUBE:   return cube_plane(idx, $urandom_range(1, 4000));
         STYLE_TILTED: return {16'($urandom_range(0, 2000)),
                               16'(int'($urandom_range(0, 32768)) - 16384),
                               16'(int'($urandom_range(0, 32768)) - 16384),
                               16'(int'($urandom_range(0, 32768)) - 16384)};
         STYLE_RAW:    return {$urandom, $urandom};
         STYLE_CORNER: return {corner_field(), corner_field(), corner_field(), corner_field()};
         default:      return '0;
      endcase
   endfunction

   function automatic int style_span(plane_style_type style);
      case (style)
         STYLE_CUBE:   return 6000;
         STYLE_TILTED: return 4000;
         default:      return 32767;
      endcase
   endfunction

   function automatic logic [CBITS-1:0] pick_coord(int span);
      if ($urandom_range(0, 9) < 7) return CBITS'(int'($urandom_range(0, 2 * span)) - span);
      return CBITS'($urandom);
   endfunction

   function automatic logic [CBITS-2:0] pick_size(int span);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return (CBITS-1)'($urandom_range(0, span / 2));
         6, 7:             return (CBITS-1)'($urandom);
         8:                return '1;
         default:          return '0;
      endcase
   endfunction

   function automatic cull_req_type random_request(int span);
      cull_req_type r;
      r.op  = $urandom_range(0, 1) ? fcbs_pkg::OP_SPHERE : fcbs_pkg::OP_BOX;
      r.cx  = pick_coord(span);
      r.cy  = pick_coord(span);
      r.cz  = pick_coord(span);
      r.ex  = pick_size(span);
      r.ey  = pick_size(span);
      r.ez  = pick_size(span);
      r.rad = pick_size(span);
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Present one test, hold it until taken, then idle for the given gap
   task automatic send_item(cull_req_type r, int gap);
      req_operation <= r.op;
      req_center_x  <= r.cx;
      req_center_y  <= r.cy;
      req_center_z  <= r.cz;
      req_extent_x  <= r.ex;
      req_extent_y  <= r.ey;
      req_extent_z  <= r.ez;
      req_radius    <= r.rad;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One APB write transfer, then psel and penable drop
   task automatic write_csr(int idx, logic [63:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ABITS'(idx * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.set_plane(idx, value);
      csr_accesses++;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One APB read transfer, checked against the tracked plane
   task automatic read_back(int idx);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= ABITS'(idx * 8);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== sb.planes[idx]) sb.flag("plane read back", sb.planes[idx], prdata);
      csr_accesses++;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drop start and wait until every result has come back
   task automatic settle();
      start <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_planes(plane_style_type style);
      for (int i = 0; i < NPL; i++) write_csr(i, make_plane(style, i));
      // occasionally poke an address past the plane file
      if ($urandom_range(0, 2) == 0) write_csr(NPL + $urandom_range(0, 1),
                                                {$urandom, $urandom});
      for (int i = 0; i < NPL; i++) read_back(i);
      settings_run++;
   endtask

   initial begin
      plane_style_type styles [10];
      int              span;
      bit              steady;
      styles = '{STYLE_CUBE, STYLE_TILTED, STYLE_CUBE, STYLE_RAW, STYLE_TILTED,
                 STYLE_CORNER, STYLE_CUBE, STYLE_ZERO, STYLE_TILTED, STYLE_RAW};
      sb = new();
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= fcbs_pkg::OP_BOX;
      req_center_x  <= '0;
      req_center_y  <= '0;
      req_center_z  <= '0;
      req_extent_x  <= '0;
      req_extent_y  <= '0;
      req_extent_z  <= '0;
      req_radius    <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Planes straight out of reset: every distance is zero
      send_item(mk(fcbs_pkg::OP_BOX, 0, 0, 0, 32767, 32767, 32767, 0), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 5, -5, 5, 0, 0, 0, 0), 1);
      send_item(mk(fcbs_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 5), 0);
      settle();
      for (int i = 0; i < NPL; i++) read_back(i);

      // Cube of half-size 1000 around the origin
      for (int i = 0; i < NPL; i++) write_csr(i, cube_plane(i, 1000));
      write_csr(NPL, {$urandom, $urandom});
      write_csr(NPL + 1, '1);
      for (int i = 0; i < NPL; i++) read_back(i);
      settings_run++;
      send_item(mk(fcbs_pkg::OP_BOX, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(mk(fcbs_pkg::OP_BOX, -1000, 0, 0, 0, 0, 0, 0), 0);
      send_item(mk(fcbs_pkg::OP_BOX, -1001, 0, 0, 1, 0, 0, 0), 2);
      send_item(mk(fcbs_pkg::OP_BOX, -1001, 0, 0, 2, 0, 0, 0), 0);
      send_item(mk(fcbs_pkg::OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767, 0), 0);
      send_item(mk(fcbs_pkg::OP_BOX, -32768, -32768, -32768, 0, 0, 0, 0), 0);
      send_item(mk(fcbs_pkg::OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0), 3);
      send_item(mk(fcbs_pkg::OP_BOX, 5000, 0, 0, 0, 0, 0, 32767), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 999), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 1000), 1);
      send_item(mk(fcbs_pkg::OP_SPHERE, -2000, 0, 0, 0, 0, 0, 1000), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, -2000, 0, 0, 0, 0, 0, 1001), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 0, 0, 0, 32767, 32767, 32767, 32767), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 32767, -32768, 32767, 0, 0, 0, 0), 0);
      send_item(mk(fcbs_pkg::OP_SPHERE, 0, 999, -999, 0, 0, 0, 0), 0);
      settle();

      // Random phases, each under its own plane setting
      for (int ph = 0; ph < $size(styles); ph++) begin
         load_planes(styles[ph]);
         span   = style_span(styles[ph]);
         steady = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 48 == 0) steady = ($urandom_range(0, 3) == 0);
            send_item(random_request(span), steady ? 0 : pick_gap());
         end
         settle();
      end

      $display("Ran %0d box and %0d sphere tests under %0d plane settings, %0d CSR transfers",
               sb.box_tests, sb.sphere_tests, settings_run, csr_accesses);
      $display("Results seen outside/partial/inside: %0d / %0d / %0d",
               sb.vis_seen[0], sb.vis_seen[1], sb.vis_seen[2]);
      if (sb.mismatches == 0 && sb.pending_count() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
